@@ sv/lmsanc_pkg.sv @@
// Shared types and constants of the LMS adaptive noise canceller.
package lmsanc_pkg;

  // Sample and arithmetic widths fixed by the Q1.15 sample format.
  localparam int TAP_W    = 16;                    // Q1.15 sample
  localparam int MU_W     = 16;                    // unsigned Q1.15 step size
  localparam int EU_W     = 18;                    // error clamped for the update
  localparam int ME_W     = MU_W + 1 + EU_W;       // mu * e, signed
  localparam int MUL_W    = ME_W + TAP_W;          // shared multiplier result
  localparam int UPD_FRAC = 45;                    // fraction bits of mu * e * x

  // Configuration port.
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic REG_STEP_SIZE = 1'b0;
  localparam logic REG_BYPASS    = 1'b1;

  localparam logic [MU_W-1:0] STEP_SIZE_RST = 16'd16384;

  typedef struct packed {
    logic [MU_W-1:0] step_size;
    logic            bypass_error;
  } cfg_t;

endpackage

@@ sv/lmsanc_in_if.sv @@
// Input channel: primary and reference samples with valid/ready handshake.
interface lmsanc_in_if import lmsanc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [TAP_W-1:0] primary_sample;
  logic signed [TAP_W-1:0] reference_sample;

  modport source (output valid, output primary_sample, output reference_sample, input ready);
  modport sink   (input valid, input primary_sample, input reference_sample, output ready);
endinterface

@@ sv/lmsanc_out_if.sv @@
// Output channel: error (or bypassed primary) and estimate with valid/ready handshake.
interface lmsanc_out_if import lmsanc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [TAP_W-1:0] left_out;
  logic signed [TAP_W-1:0] estimate_out;

  modport source (output valid, output left_out, output estimate_out, input ready);
  modport sink   (input valid, input left_out, input estimate_out, output ready);
endinterface

@@ sv/lmsanc_regs.sv @@
// APB register file: step size and error bypass.
module lmsanc_regs import lmsanc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg_o
);

  cfg_t cfg_q;
  logic wr_en;
  logic reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_size    <= STEP_SIZE_RST;
      cfg_q.bypass_error <= 1'b0;
    end else if (wr_en) begin
      case (reg_sel)
        REG_STEP_SIZE: cfg_q.step_size    <= pwdata[MU_W-1:0];
        REG_BYPASS:    cfg_q.bypass_error <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_STEP_SIZE: prdata = {{(PDATA_W-MU_W){1'b0}}, cfg_q.step_size};
      REG_BYPASS:    prdata = {{(PDATA_W-1){1'b0}}, cfg_q.bypass_error};
      default:       prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

@@ sv/lms_adaptive_noise_canceller.sv @@
// Top level: LMS adaptive FIR noise canceller on one shared multiply-accumulate unit.
//
// Usage:
//   smp_i carries one item: a primary sample d (signal plus noise) and a reference
//   noise sample x, both Q1.15. res_o returns one item per input: left_out = d - y
//   (or d when bypass_error is set) and estimate_out = y, both saturated to 16 bits.
//   Registers (APB, byte address 4*index): step_size at 0, bypass_error at 4.
//   Write them only while the block is idle.
//
// Timing:
//   smp_i.ready is high only in the idle state. After an item is taken, one
//   multiplier walks the TAPS taps twice: a filter pass (coefficient * tap into the
//   accumulator) and an update pass (mu*e * tap, rounded, added to each
//   coefficient with saturation). The result is loaded into the output register in
//   S_OUT, after the filter pass and the S_RND and S_ERR states; a new item is taken
//   only after the update pass, back in S_IDLE. The tap walk of the shared multiplier,
//   one tap per cycle through a 3-stage read/multiply/accumulate pipeline, sets the pace.
//
// Reset clears the control state and the per-entry valid bits of the tap and
// coefficient memories, so every tap and coefficient reads as zero until written.
// A stalled receiver holds the result in the output register; the block then
// waits before the update pass until the register is free.
module lms_adaptive_noise_canceller import lmsanc_pkg::*; #(
  parameter int TAPS       = 50,
  parameter int COEF_WIDTH = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  lmsanc_in_if.sink          smp_i,
  lmsanc_out_if.source       res_o
);

  // Derived widths.
  localparam int IDX_W = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int FRAC  = COEF_WIDTH - 2;          // coefficient fraction bits
  localparam int PF_W  = COEF_WIDTH + TAP_W;      // filter product width
  localparam int ACC_W = PF_W + $clog2(TAPS) + 1; // exact sum over all taps
  localparam int Y_W   = ACC_W + 1 - FRAC;        // estimate after rounding
  localparam int E_W   = Y_W + 1;                 // d - y
  localparam int SH    = UPD_FRAC - FRAC;         // update rounding shift
  localparam int DLT_W = MUL_W + 1 - SH;          // coefficient increment
  localparam int SUM_W = ((DLT_W > COEF_WIDTH) ? DLT_W : COEF_WIDTH) + 1;

  localparam logic [IDX_W-1:0] LAST = IDX_W'(TAPS - 1);

  localparam logic signed [ACC_W:0] Y_HALF =
    {{(ACC_W + 1 - FRAC){1'b0}}, 1'b1, {(FRAC - 1){1'b0}}};
  localparam logic signed [MUL_W:0] D_HALF =
    {{(MUL_W + 1 - SH){1'b0}}, 1'b1, {(SH - 1){1'b0}}};

  localparam logic signed [Y_W-1:0] Y_MAX16 = {{(Y_W - 15){1'b0}}, {15{1'b1}}};
  localparam logic signed [Y_W-1:0] Y_MIN16 = {{(Y_W - 15){1'b1}}, {15{1'b0}}};
  localparam logic signed [E_W-1:0] E_MAX16 = {{(E_W - 15){1'b0}}, {15{1'b1}}};
  localparam logic signed [E_W-1:0] E_MIN16 = {{(E_W - 15){1'b1}}, {15{1'b0}}};
  localparam logic signed [E_W-1:0] E_MAXU  = {{(E_W - 17){1'b0}}, {17{1'b1}}};
  localparam logic signed [E_W-1:0] E_MINU  = {{(E_W - 17){1'b1}}, {17{1'b0}}};
  localparam logic signed [SUM_W-1:0] C_MAX =
    {{(SUM_W - COEF_WIDTH + 1){1'b0}}, {(COEF_WIDTH - 1){1'b1}}};
  localparam logic signed [SUM_W-1:0] C_MIN =
    {{(SUM_W - COEF_WIDTH + 1){1'b1}}, {(COEF_WIDTH - 1){1'b0}}};

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;  // wait for an item
  localparam logic [2:0] S_FILT = 3'd1;  // filter pass over the taps
  localparam logic [2:0] S_RND  = 3'd2;  // round the sum to y
  localparam logic [2:0] S_ERR  = 3'd3;  // form e = d - y
  localparam logic [2:0] S_OUT  = 3'd4;  // form mu*e, hand out the result
  localparam logic [2:0] S_UPD  = 3'd5;  // coefficient update pass

  cfg_t cfg;

  lmsanc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Memories: tap delay line as a circular buffer, coefficients by tap index.
  logic signed [TAP_W-1:0]      tap_mem  [TAPS];
  logic signed [COEF_WIDTH-1:0] coef_mem [TAPS];
  logic [TAPS-1:0]              tap_vld_q;
  logic [TAPS-1:0]              coef_vld_q;

  logic [2:0]       state_q, state_d;
  logic [IDX_W-1:0] ptr_q;        // slot of the newest sample
  logic [IDX_W-1:0] ptr_new;
  logic [IDX_W-1:0] slot_q;       // tap slot being read
  logic [IDX_W-1:0] cnt_q;        // tap index being read
  logic             issue_q;
  logic             s1_vld_q, s2_vld_q, s3_vld_q;
  logic             in_acc;
  logic             pass_done;

  // Pipeline payload.
  logic signed [TAP_W-1:0]      tap_rd_q;
  logic signed [COEF_WIDTH-1:0] coef_rd_q;
  logic                         tap_ok_q, coef_ok_q;
  logic [IDX_W-1:0]             s1_idx_q, s2_idx_q, s3_idx_q;
  logic signed [TAP_W-1:0]      tap_eff;
  logic signed [COEF_WIDTH-1:0] coef_eff;
  logic signed [ME_W-1:0]       mul_a;
  logic signed [MUL_W-1:0]      mul_p;
  logic signed [MUL_W-1:0]      prod_q;
  logic signed [COEF_WIDTH-1:0] s2_coef_q, s3_coef_q;
  logic signed [MUL_W:0]        dsum;
  logic signed [DLT_W-1:0]      delta_q;
  logic signed [SUM_W-1:0]      csum;
  logic signed [COEF_WIDTH-1:0] coef_new;

  // Per-item values.
  logic signed [TAP_W-1:0] d_q;
  logic signed [ACC_W-1:0] acc_q;
  logic signed [ACC_W:0]   ysum;
  logic signed [Y_W-1:0]   y_q;
  logic signed [E_W-1:0]   e_q;
  logic signed [EU_W-1:0]  eu;
  logic signed [MU_W:0]    mu_s;
  logic signed [ME_W-1:0]  me_q;
  logic signed [TAP_W-1:0] e16, y16;

  // Output register.
  logic                    out_vld_q;
  logic                    out_load;
  logic signed [TAP_W-1:0] left_q, est_q;

  assign smp_i.ready = (state_q == S_IDLE);
  assign in_acc      = smp_i.valid & smp_i.ready;
  assign ptr_new     = (ptr_q == LAST) ? '0 : ptr_q + 1'b1;
  assign pass_done   = !issue_q && !s1_vld_q && !s2_vld_q && !s3_vld_q;
  assign out_load    = (state_q == S_OUT) && (!out_vld_q || res_o.ready);

  // Sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_acc) state_d = S_FILT;
      S_FILT: if (pass_done) state_d = S_RND;
      S_RND:  state_d = S_ERR;
      S_ERR:  state_d = S_OUT;
      S_OUT:  if (out_load) state_d = S_UPD;
      S_UPD:  if (pass_done) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Walk control: issue one tap read per cycle, then drain the pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ptr_q    <= '0;
      slot_q   <= '0;
      cnt_q    <= '0;
      issue_q  <= 1'b0;
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      s1_vld_q <= issue_q;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q && (state_q == S_UPD);
      if (in_acc) begin
        ptr_q   <= ptr_new;
        slot_q  <= ptr_new;
        cnt_q   <= '0;
        issue_q <= 1'b1;
      end else if (out_load) begin
        slot_q  <= ptr_q;
        cnt_q   <= '0;
        issue_q <= 1'b1;
      end else if (issue_q) begin
        slot_q <= (slot_q == '0) ? LAST : slot_q - 1'b1;
        cnt_q  <= cnt_q + 1'b1;
        if (cnt_q == LAST) begin
          issue_q <= 1'b0;
        end
      end
    end
  end

  // Valid bits: an entry never written reads as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_vld_q  <= '0;
      coef_vld_q <= '0;
    end else begin
      if (in_acc) begin
        tap_vld_q[ptr_new] <= 1'b1;
      end
      if (s3_vld_q) begin
        coef_vld_q[s3_idx_q] <= 1'b1;
      end
    end
  end

  // Tap memory: push the reference sample, read one slot a cycle.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      tap_mem[ptr_new] <= smp_i.reference_sample;
    end
    tap_rd_q <= tap_mem[slot_q];
    tap_ok_q <= tap_vld_q[slot_q];
  end

  // Coefficient memory: read ahead, write back at the end of the update pipe.
  always_ff @(posedge clk_i) begin
    if (s3_vld_q) begin
      coef_mem[s3_idx_q] <= coef_new;
    end
    coef_rd_q <= coef_mem[cnt_q];
    coef_ok_q <= coef_vld_q[cnt_q];
    s1_idx_q  <= cnt_q;
  end

  // Shared multiplier: coefficient in the filter pass, mu*e in the update pass.
  assign tap_eff  = tap_ok_q ? tap_rd_q : '0;
  assign coef_eff = coef_ok_q ? coef_rd_q : '0;

  always_comb begin
    if (state_q == S_UPD) begin
      mul_a = me_q;
    end else begin
      mul_a = {{(ME_W - COEF_WIDTH){coef_eff[COEF_WIDTH-1]}}, coef_eff};
    end
    mul_p = mul_a * tap_eff;
  end

  // Update increment: round half up, then add with saturation.
  assign dsum = {prod_q[MUL_W-1], prod_q} + D_HALF;
  assign csum = {{(SUM_W - COEF_WIDTH){s3_coef_q[COEF_WIDTH-1]}}, s3_coef_q}
              + {{(SUM_W - DLT_W){delta_q[DLT_W-1]}}, delta_q};

  always_comb begin
    if (csum > C_MAX) begin
      coef_new = C_MAX[COEF_WIDTH-1:0];
    end else if (csum < C_MIN) begin
      coef_new = C_MIN[COEF_WIDTH-1:0];
    end else begin
      coef_new = csum[COEF_WIDTH-1:0];
    end
  end

  // Datapath pipeline registers.
  always_ff @(posedge clk_i) begin
    if (s1_vld_q) begin
      prod_q    <= mul_p;
      s2_coef_q <= coef_eff;
      s2_idx_q  <= s1_idx_q;
    end
    if (s2_vld_q) begin
      delta_q   <= dsum[MUL_W:SH];
      s3_coef_q <= s2_coef_q;
      s3_idx_q  <= s2_idx_q;
    end
  end

  // Per-item arithmetic: accumulate, round, error, step.
  assign ysum = {acc_q[ACC_W-1], acc_q} + Y_HALF;
  assign mu_s = {1'b0, cfg.step_size};

  always_comb begin
    if (e_q > E_MAXU) begin
      eu = E_MAXU[EU_W-1:0];
    end else if (e_q < E_MINU) begin
      eu = E_MINU[EU_W-1:0];
    end else begin
      eu = e_q[EU_W-1:0];
    end
    if (e_q > E_MAX16) begin
      e16 = E_MAX16[TAP_W-1:0];
    end else if (e_q < E_MIN16) begin
      e16 = E_MIN16[TAP_W-1:0];
    end else begin
      e16 = e_q[TAP_W-1:0];
    end
    if (y_q > Y_MAX16) begin
      y16 = Y_MAX16[TAP_W-1:0];
    end else if (y_q < Y_MIN16) begin
      y16 = Y_MIN16[TAP_W-1:0];
    end else begin
      y16 = y_q[TAP_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      d_q   <= smp_i.primary_sample;
      acc_q <= '0;
    end else if (s2_vld_q && (state_q == S_FILT)) begin
      acc_q <= acc_q + {{(ACC_W - PF_W){prod_q[PF_W-1]}}, prod_q[PF_W-1:0]};
    end
    if (state_q == S_RND) begin
      y_q <= ysum[ACC_W:FRAC];
    end
    if (state_q == S_ERR) begin
      e_q <= {{(E_W - TAP_W){d_q[TAP_W-1]}}, d_q} - {y_q[Y_W-1], y_q};
    end
    if (state_q == S_OUT) begin
      me_q <= mu_s * eu;
    end
  end

  // Output register: hold the result until the receiver takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (res_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      left_q <= cfg.bypass_error ? d_q : e16;
      est_q  <= y16;
    end
  end

  assign res_o.valid        = out_vld_q;
  assign res_o.left_out     = left_q;
  assign res_o.estimate_out = est_q;

endmodule

@@ sv/lmsanc_chk.sv @@
// Port-level checker of the LMS noise canceller, bound to the top level.
module lmsanc_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [15:0] left_i,
  input logic [15:0] est_i
);

  // A result waiting for the receiver stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(left_i) && $stable(est_i))
    else $error("result payload changed while stalled");

  // An accepted item closes the input; only the drop of ready right after acceptance is checked.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input reopened right after an item");

  // A new result shows up only while the block is still busy with its item.
  a_result_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !in_ready_i)
    else $error("result raised while idle");

endmodule

bind lms_adaptive_noise_canceller lmsanc_chk u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (smp_i.valid),
  .in_ready_i  (smp_i.ready),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .left_i      (res_o.left_out),
  .est_i       (res_o.estimate_out)
);
